// File: rtl/lsh_pkg.sv
// Shared types, register indexes and reset values for the link speedup handshake.
package lsh_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 32;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SELF_ID      = 2'd0,
		REG_RETRY_MS     = 2'd1,
		REG_MAX_ATTEMPTS = 2'd2,
		REG_SPEEDUP_DIV  = 2'd3
	} cfg_reg_t;

	localparam logic [31:0] SelfIdRst = 32'd0;
	localparam logic [15:0] RetryMsRst = 16'd500;
	localparam logic [3:0] MaxAttemptsRst = 4'd8;
	localparam logic [4:0] SpeedupDivRst = 5'd2;

	localparam logic [4:0] StockDiv = 5'd1;
	localparam logic [4:0] MaxDiv = 5'd16;

	typedef enum logic {
		FUNC_TICK   = 1'b0,
		FUNC_PACKET = 1'b1
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] now_ms;
		logic        connected;
		logic        eligible;
		logic        is_client;
		logic        packet_valid;
		logic [31:0] peer_id;
	} req_t;

	typedef struct packed {
		logic       send_hello;
		logic       send_reply;
		logic       divisor_write;
		logic [4:0] divisor_value;
		logic       is_confirmed;
		logic       gave_up;
		logic [3:0] attempt_count;
	} rsp_t;

endpackage

// File: rtl/lsh_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface lsh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/link_speedup_handshake.sv
// Link speedup handshake: negotiates a faster wire divisor with a single peer.
//
// Channels: req (sink) takes one word per frame tick or received negotiation
// packet; rsp (source) returns exactly one word per req word, in order, with
// hello/reply requests, an optional divisor write and the session state.
// Configuration: cfg_we/cfg_index/cfg_data write self id, retry interval,
// attempt limit and speedup divisor; write only while no word is in flight.
// Path: a taken word is registered in the input register, then in the result
// register, which drives rsp.
// Throughput: one word per cycle while rsp is not held off; the session state
// is updated in the same cycle that loads the result register, so the next
// word sees it directly.
// Reset: all session flags, counters, the last send time and the registers
// return to their reset values; no word is pending afterwards.
// Stall: when rsp is held off, the result register holds, the input register
// holds behind it, and req ready drops only once both are full.
module link_speedup_handshake (
	input  logic                          clk,
	input  logic                          arst_n,
	lsh_stream_if.sink                    req,
	lsh_stream_if.source                  rsp,
	input  logic                          cfg_we,
	input  logic [lsh_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lsh_pkg::CfgDataW-1:0]  cfg_data
);

	// configuration registers
	logic [31:0] self_id_q;
	logic [15:0] retry_ms_q;
	logic [3:0]  max_attempts_q;
	logic [4:0]  speedup_div_q;

	// session state
	logic        confirmed_q;
	logic        gave_up_q;
	logic [3:0]  attempts_q;
	logic [31:0] last_send_q;
	logic        was_conn_q;

	// pipeline
	logic          valid_s1;
	lsh_pkg::req_t req_s1;
	logic          valid_s2;
	lsh_pkg::rsp_t rsp_s2;
	logic          advance;

	// next-state and result logic
	logic          confirmed_d;
	logic          gave_up_d;
	logic [3:0]    attempts_d;
	logic [31:0]   last_send_d;
	logic          was_conn_d;
	lsh_pkg::rsp_t rsp_d;
	logic [31:0]   elapsed;
	logic [4:0]    div_clamped;

	assign advance = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = valid_s2;
	assign rsp.data = rsp_s2;

	assign elapsed = req_s1.now_ms - last_send_q;

	always_comb begin
		if (speedup_div_q == 5'd0) begin
			div_clamped = lsh_pkg::StockDiv;
		end else if (speedup_div_q > lsh_pkg::MaxDiv) begin
			div_clamped = lsh_pkg::MaxDiv;
		end else begin
			div_clamped = speedup_div_q;
		end
	end

	always_comb begin
		confirmed_d = confirmed_q;
		gave_up_d = gave_up_q;
		attempts_d = attempts_q;
		last_send_d = last_send_q;
		was_conn_d = was_conn_q;
		rsp_d = '0;
		rsp_d.divisor_value = lsh_pkg::StockDiv;
		unique case (req_s1.func)
			lsh_pkg::FUNC_TICK: begin
				if (!req_s1.eligible || !req_s1.connected) begin
					// fall back to stock timing
					if (confirmed_q || attempts_q != 4'd0 || gave_up_q) begin
						confirmed_d = 1'b0;
						gave_up_d = 1'b0;
						attempts_d = 4'd0;
						rsp_d.divisor_write = 1'b1;
					end
					was_conn_d = req_s1.connected;
				end else begin
					if (!was_conn_q) begin
						// fresh connection: restart the session
						confirmed_d = 1'b0;
						gave_up_d = 1'b0;
						attempts_d = 4'd0;
						rsp_d.divisor_write = 1'b1;
					end
					was_conn_d = 1'b1;
					if (!confirmed_d && !gave_up_d && req_s1.is_client &&
					    !(attempts_d != 4'd0 && elapsed < {16'd0, retry_ms_q})) begin
						if (attempts_d >= max_attempts_q) begin
							gave_up_d = 1'b1;
						end else begin
							rsp_d.send_hello = 1'b1;
							attempts_d = attempts_d + 4'd1;
							last_send_d = req_s1.now_ms;
						end
					end
				end
			end
			lsh_pkg::FUNC_PACKET: begin
				if (req_s1.packet_valid && req_s1.peer_id != self_id_q &&
				    req_s1.eligible && !confirmed_q) begin
					confirmed_d = 1'b1;
					rsp_d.divisor_write = 1'b1;
					rsp_d.divisor_value = div_clamped;
					rsp_d.send_reply = 1'b1;
				end
			end
			default: begin
			end
		endcase
		rsp_d.is_confirmed = confirmed_d;
		rsp_d.gave_up = gave_up_d;
		rsp_d.attempt_count = attempts_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q <= lsh_pkg::SelfIdRst;
			retry_ms_q <= lsh_pkg::RetryMsRst;
			max_attempts_q <= lsh_pkg::MaxAttemptsRst;
			speedup_div_q <= lsh_pkg::SpeedupDivRst;
		end else if (cfg_we) begin
			unique case (lsh_pkg::cfg_reg_t'(cfg_index))
				lsh_pkg::REG_SELF_ID:      self_id_q <= cfg_data;
				lsh_pkg::REG_RETRY_MS:     retry_ms_q <= cfg_data[15:0];
				lsh_pkg::REG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[3:0];
				lsh_pkg::REG_SPEEDUP_DIV:  speedup_div_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirmed_q <= 1'b0;
			gave_up_q <= 1'b0;
			attempts_q <= 4'd0;
			last_send_q <= 32'd0;
			was_conn_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				confirmed_q <= confirmed_d;
				gave_up_q <= gave_up_d;
				attempts_q <= attempts_d;
				last_send_q <= last_send_d;
				was_conn_q <= was_conn_d;
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp_s2.divisor_write |-> rsp_s2.divisor_value == lsh_pkg::StockDiv)
		else $error("divisor value not stock while no divisor write");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(rsp_s2.send_hello && rsp_s2.send_reply))
		else $error("hello and reply in the same word");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.send_hello |-> rsp_s2.attempt_count != 4'd0)
		else $error("hello sent with zero attempt count");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("stalled input word lost or changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 && rsp_s2.attempt_count == attempts_q &&
			rsp_s2.is_confirmed == confirmed_q)
		else $error("result word disagrees with session state");
`endif

endmodule
